/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the cubic bisection root finder.
// Depends on nothing; the using module supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define CBR_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CBR_ASSERT(lbl, prop)
`define CBR_NEVER(lbl, expr)
`endif
`endif

/* hdl/cbr_pkg.sv */
// Package of the cubic bisection root finder: widths, codes and word types.
// Depends on nothing.
package cbr_pkg;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int LIMB_W = 32;
  localparam int NLIMB = 5;
  localparam int ACC_W = LIMB_W * NLIMB;
  localparam int NUM_W = DATA_WIDTH + 7;
  localparam int REM_W = 2 * DATA_WIDTH;
  localparam int IT_W = 7;
  localparam logic [IT_W-1:0] CAP_MAX = IT_W'(64);

  localparam logic [2:0] CFG_COEF_CONST = 3'd0;
  localparam logic [2:0] CFG_COEF_LINEAR = 3'd1;
  localparam logic [2:0] CFG_COEF_SQUARE = 3'd2;
  localparam logic [2:0] CFG_COEF_CUBE = 3'd3;
  localparam logic [2:0] CFG_TOLERANCE = 3'd4;
  localparam logic [2:0] CFG_MAX_ITER = 3'd5;

  typedef enum logic [1:0] {
    STAT_CONVERGED = 2'd0,
    STAT_EXACT = 2'd1,
    STAT_NO_ROOT = 2'd2,
    STAT_LIMIT = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] lower_end;
    logic signed [DATA_WIDTH-1:0] upper_end;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] root;
    logic [DATA_WIDTH-1:0] error_pct;
    logic [IT_W-1:0] iterations;
    status_e status;
  } out_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] coef_const;
    logic signed [DATA_WIDTH-1:0] coef_linear;
    logic signed [DATA_WIDTH-1:0] coef_square;
    logic signed [DATA_WIDTH-1:0] coef_cube;
  } coef_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;
endpackage

/* hdl/cubic_bisection_root_finder.sv */
// Top level of the cubic bisection root finder: configuration registers and
// the bisection sequencer. Depends on cbr_pkg, cbr_cubic_sign, cbr_rel_error
// and assert_macros.svh. The cubic is first evaluated at both ends of a word.
// Each midpoint is then formed, the cubic is evaluated at it on the shared
// limb multiplier, the signs are checked and, short of an exact root, the error
// is found by bit-serial division (cut short when it saturates), for up to 64
// iterations. The result is shown for one cycle with done_o, in the cycle after
// the last step, and cannot be held off; busy is high from acceptance until the
// last step and is low again when done_o is shown.
`include "assert_macros.svh"
module cubic_bisection_root_finder (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cbr_pkg::in_word_t in_word_i,
  output logic done_o,
  output cbr_pkg::out_word_t out_word_o,
  input  logic cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [cbr_pkg::DATA_WIDTH-1:0] cfg_wdata_i
);
  import cbr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL_A = 7'b0000010,
    S_EVAL_B = 7'b0000100,
    S_MID = 7'b0001000,
    S_EVAL_C = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DIV = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  coef_t coef_q;
  logic [DATA_WIDTH-1:0] tol_q;
  logic [IT_W-1:0] max_it_q, cap_q, cap_d, iter_q, iter_d;
  logic signed [DATA_WIDTH-1:0] a_q, a_d, b_q, b_d, c_q, c_d, prev_q, prev_d;
  logic signed [DATA_WIDTH-1:0] x_q, x_d;
  sign_t sa_q, sa_d, sc_q, sc_d;
  logic cub_go_q, cub_go_d, div_go_q, div_go_d;
  logic done_q, done_d;
  out_word_t res_q, res_d;
  logic cub_done, div_done;
  sign_t cub_sign;
  logic [DATA_WIDTH-1:0] div_err;
  logic [DATA_WIDTH:0] mid_sum;
  logic signed [DATA_WIDTH-1:0] mid;
  logic accept;

  cbr_cubic_sign u_cubic (
    .clk_i (clk_i),
    .rst_ni (rst_ni),
    .go_i (cub_go_q),
    .x_i (x_q),
    .coef_i (coef_q),
    .done_o (cub_done),
    .sign_o (cub_sign)
  );

  cbr_rel_error u_err (
    .clk_i (clk_i),
    .rst_ni (rst_ni),
    .go_i (div_go_q),
    .c_i (c_q),
    .prev_i (prev_q),
    .done_o (div_done),
    .err_o (div_err)
  );

  assign accept = start && !busy;
  assign mid_sum = {a_q[DATA_WIDTH-1], a_q} + {b_q[DATA_WIDTH-1], b_q};
  assign mid = mid_sum[DATA_WIDTH:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.coef_const <= DATA_WIDTH'(-131072);
      coef_q.coef_linear <= DATA_WIDTH'(458752);
      coef_q.coef_square <= DATA_WIDTH'(-327680);
      coef_q.coef_cube <= DATA_WIDTH'(393216);
      tol_q <= DATA_WIDTH'(66);
      max_it_q <= CAP_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_CONST: coef_q.coef_const <= cfg_wdata_i;
        CFG_COEF_LINEAR: coef_q.coef_linear <= cfg_wdata_i;
        CFG_COEF_SQUARE: coef_q.coef_square <= cfg_wdata_i;
        CFG_COEF_CUBE: coef_q.coef_cube <= cfg_wdata_i;
        CFG_TOLERANCE: tol_q <= cfg_wdata_i;
        CFG_MAX_ITER: max_it_q <= cfg_wdata_i[IT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    prev_d = prev_q;
    x_d = x_q;
    sa_d = sa_q;
    sc_d = sc_q;
    cap_d = cap_q;
    iter_d = iter_q;
    cub_go_d = 1'b0;
    div_go_d = 1'b0;
    done_d = 1'b0;
    res_d = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          a_d = in_word_i.lower_end;
          b_d = in_word_i.upper_end;
          prev_d = in_word_i.lower_end;
          x_d = in_word_i.lower_end;
          iter_d = '0;
          if (max_it_q == '0) begin
            cap_d = IT_W'(1);
          end else if (max_it_q > CAP_MAX) begin
            cap_d = CAP_MAX;
          end else begin
            cap_d = max_it_q;
          end
          cub_go_d = 1'b1;
          state_d = S_EVAL_A;
        end
      end
      S_EVAL_A: begin
        if (cub_done) begin
          sa_d = cub_sign;
          x_d = b_q;
          cub_go_d = 1'b1;
          state_d = S_EVAL_B;
        end
      end
      S_EVAL_B: begin
        if (cub_done) begin
          if (!sa_q.zero && !cub_sign.zero && (sa_q.neg == cub_sign.neg)) begin
            res_d.root = '0;
            res_d.error_pct = '0;
            res_d.iterations = '0;
            res_d.status = STAT_NO_ROOT;
            done_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_MID;
          end
        end
      end
      S_MID: begin
        c_d = mid;
        x_d = mid;
        iter_d = iter_q + 1'b1;
        cub_go_d = 1'b1;
        state_d = S_EVAL_C;
      end
      S_EVAL_C: begin
        if (cub_done) begin
          sc_d = cub_sign;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sc_q.zero || sa_q.zero) begin
          res_d.root = sc_q.zero ? c_q : a_q;
          res_d.error_pct = '0;
          res_d.iterations = iter_q;
          res_d.status = STAT_EXACT;
          done_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          if (sa_q.neg == sc_q.neg) begin
            a_d = c_q;
            sa_d = sc_q;
          end else begin
            b_d = c_q;
          end
          div_go_d = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          prev_d = c_q;
          res_d.root = c_q;
          res_d.error_pct = div_err;
          res_d.iterations = iter_q;
          if (div_err <= tol_q) begin
            res_d.status = STAT_CONVERGED;
            done_d = 1'b1;
            state_d = S_IDLE;
          end else if (iter_q >= cap_q) begin
            res_d.status = STAT_LIMIT;
            done_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_MID;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cub_go_q <= 1'b0;
      div_go_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      cap_q <= CAP_MAX;
    end else begin
      state_q <= state_d;
      cub_go_q <= cub_go_d;
      div_go_q <= div_go_d;
      done_q <= done_d;
      iter_q <= iter_d;
      cap_q <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    prev_q <= prev_d;
    x_q <= x_d;
    sa_q <= sa_d;
    sc_q <= sc_d;
    res_q <= res_d;
  end

  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;
  assign out_word_o = res_q;

  `CBR_ASSERT(a_accept_busy, accept |=> busy)
  `CBR_ASSERT(a_done_single, done_o |=> !done_o)
  `CBR_NEVER(a_iter_zero, done_o && (out_word_o.status != STAT_NO_ROOT) &&
             (out_word_o.iterations == '0))
  `CBR_NEVER(a_iter_cap, busy && (iter_q > cap_q))
endmodule

/* hdl/cbr_cubic_sign.sv */
// Exact sign of the cubic at one point, by Horner's rule on a shared
// 32x32 multiplier working one limb per cycle. Depends on cbr_pkg.
module cbr_cubic_sign (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic go_i,
  input  logic signed [cbr_pkg::DATA_WIDTH-1:0] x_i,
  input  cbr_pkg::coef_t coef_i,
  output logic done_o,
  output cbr_pkg::sign_t sign_o
);
  import cbr_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_MUL = 4'b0010,
    C_ADD = 4'b0100,
    C_FIN = 4'b1000
  } cstate_e;

  cstate_e state_q, state_d;
  logic [ACC_W-1:0] acc_q, acc_d, prod_q, prod_d;
  logic [2*LIMB_W-1:0] pp_q, pp_d;
  logic [LIMB_W-1:0] mag_q, mag_d;
  logic neg_q, neg_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] step_q, step_d;
  logic [NLIMB-1:0][LIMB_W-1:0] limbs;
  logic [LIMB_W-1:0] limb;
  logic [2:0] sh;
  logic [ACC_W-1:0] pp_sh, coef_sh, prod_sel;

  function automatic logic [ACC_W-1:0] sx(input logic [DATA_WIDTH-1:0] v);
    sx = {{(ACC_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
  endfunction

  assign limbs = acc_q;
  assign limb = (cnt_q < 3'(NLIMB)) ? limbs[cnt_q] : '0;
  assign sh = cnt_q - 3'd1;
  assign pp_sh = ACC_W'(pp_q) << {sh, 5'b0};
  assign prod_sel = neg_q ? ~prod_q : prod_q;

  always_comb begin
    case (step_q)
      2'd0: coef_sh = sx(coef_i.coef_square) << FRAC_BITS;
      2'd1: coef_sh = sx(coef_i.coef_linear) << (2 * FRAC_BITS);
      default: coef_sh = sx(coef_i.coef_const) << (3 * FRAC_BITS);
    endcase
  end

  always_comb begin
    state_d = state_q;
    acc_d = acc_q;
    prod_d = prod_q;
    pp_d = 64'(limb) * 64'(mag_q);
    mag_d = mag_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    step_d = step_q;
    unique case (state_q)
      C_IDLE: begin
        if (go_i) begin
          acc_d = sx(coef_i.coef_cube);
          neg_d = x_i[DATA_WIDTH-1];
          mag_d = x_i[DATA_WIDTH-1] ? LIMB_W'(-x_i) : LIMB_W'(x_i);
          prod_d = '0;
          cnt_d = '0;
          step_d = '0;
          state_d = C_MUL;
        end
      end
      C_MUL: begin
        if (cnt_q != 3'd0) begin
          prod_d = prod_q + pp_sh;
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(NLIMB)) begin
          state_d = C_ADD;
        end
      end
      C_ADD: begin
        acc_d = prod_sel + coef_sh + ACC_W'(neg_q);
        prod_d = '0;
        cnt_d = '0;
        step_d = step_q + 2'd1;
        state_d = (step_q == 2'd2) ? C_FIN : C_MUL;
      end
      C_FIN: begin
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q <= '0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    prod_q <= prod_d;
    pp_q <= pp_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  assign done_o = (state_q == C_FIN);
  assign sign_o.neg = acc_q[ACC_W-1];
  assign sign_o.zero = (acc_q == '0);
endmodule

/* hdl/cbr_rel_error.sv */
// Relative percent change of the midpoint, |c - prev| * 100 / |c| in
// fixed point, by restoring division one bit per cycle. Depends on cbr_pkg.
module cbr_rel_error (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic go_i,
  input  logic signed [cbr_pkg::DATA_WIDTH-1:0] c_i,
  input  logic signed [cbr_pkg::DATA_WIDTH-1:0] prev_i,
  output logic done_o,
  output logic [cbr_pkg::DATA_WIDTH-1:0] err_o
);
  import cbr_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_LOAD = 5'b00010,
    D_CHK = 5'b00100,
    D_RUN = 5'b01000,
    D_FIN = 5'b10000
  } dstate_e;

  dstate_e state_q, state_d;
  logic [DATA_WIDTH-1:0] den_q, den_d, q_q, q_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [REM_W-1:0] rem_q, rem_d, dv_q, dv_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_WIDTH:0] diff;
  logic [DATA_WIDTH-1:0] diff_mag;
  logic [NUM_W-1:0] dx;
  logic ge;

  assign diff = {c_i[DATA_WIDTH-1], c_i} - {prev_i[DATA_WIDTH-1], prev_i};
  assign diff_mag = diff[DATA_WIDTH] ? DATA_WIDTH'(-diff) : DATA_WIDTH'(diff);
  assign dx = NUM_W'(diff_mag);
  assign ge = (rem_q >= dv_q);

  always_comb begin
    state_d = state_q;
    den_d = den_q;
    num_d = num_q;
    rem_d = rem_q;
    dv_d = dv_q;
    q_d = q_q;
    cnt_d = cnt_q;
    unique case (state_q)
      D_IDLE: begin
        if (go_i) begin
          state_d = D_LOAD;
        end
      end
      D_LOAD: begin
        den_d = c_i[DATA_WIDTH-1] ? DATA_WIDTH'(-c_i) : DATA_WIDTH'(c_i);
        num_d = (dx << 6) + (dx << 5) + (dx << 2);
        state_d = D_CHK;
      end
      D_CHK: begin
        if ((den_q == '0) ||
            (REM_W'(num_q) >= (REM_W'(den_q) << (DATA_WIDTH - FRAC_BITS)))) begin
          q_d = '1;
          state_d = D_FIN;
        end else begin
          rem_d = REM_W'(num_q) << FRAC_BITS;
          dv_d = REM_W'(den_q) << (DATA_WIDTH - 1);
          q_d = '0;
          cnt_d = '0;
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        if (ge) begin
          rem_d = rem_q - dv_q;
        end
        q_d = {q_q[DATA_WIDTH-2:0], ge};
        dv_d = dv_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
          state_d = D_FIN;
        end
      end
      D_FIN: begin
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    num_q <= num_d;
    rem_q <= rem_d;
    dv_q <= dv_d;
    q_q <= q_d;
  end

  assign done_o = (state_q == D_FIN);
  assign err_o = q_q;
endmodule
